[rtl/adc_trim_calibrated_correction_unit_macros.svh]
// Assertion helpers for the top-level RTL. Each use names a label and the checked
// expressions; the clock is clk and the active-low reset is rst_n.
`ifndef ADC_TRIM_CALIBRATED_CORRECTION_UNIT_MACROS_SVH
`define ADC_TRIM_CALIBRATED_CORRECTION_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ACC_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define ACC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ACC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ACC_ASSERT_ALWAYS(lbl, expr)
`define ACC_ASSERT_IMP(lbl, ante, cons)
`define ACC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/acc_pkg.sv]
package acc_pkg;

  localparam int RAW_BITS = 12;
  localparam int CH_W     = 5;
  localparam int GAIN_W   = 13;
  localparam int D_W      = 10;
  localparam int M_W      = 20;
  localparam int Q_W      = 11;
  localparam int K_W      = 11;
  localparam int X_W      = 11;
  localparam int B_W      = 23;
  localparam int N_W      = 23;
  localparam int CCM_W    = 14;
  localparam int CC_W     = 15;
  localparam int MV_W     = 18;
  localparam int RS_W     = 15;

  localparam int SCALE    = 1000;
  localparam int X1_MAIN  = 1441;
  localparam int X1_LOW   = 150;

  // Reciprocals for exact truncating division of a 20-bit value by the code spans.
  localparam int RECIP_W     = 23;
  localparam int RECIP_SHIFT = 32;
  localparam logic [RECIP_W-1:0] RECIP_DX_MAIN = 23'd2340582;
  localparam logic [RECIP_W-1:0] RECIP_DX_LOW  = 23'd7146369;

  // Reciprocal of 1000 for products below 2**27.
  localparam int R1K_W     = 28;
  localparam int R1K_SHIFT = 37;
  localparam logic [R1K_W-1:0] RECIP_1000 = 28'd137438954;

  localparam int MV_MAX = 131071;
  localparam int MV_MIN = -131072;
  localparam int RS_MAX = 32767;

  localparam int MQ_DEPTH = 8;
  localparam int MQ_AW    = 3;
  localparam int OQ_DEPTH = 32;
  localparam int OQ_AW    = 5;

  localparam logic [CH_W-1:0] CH_GRP_A      = 5'd7;
  localparam logic [CH_W-1:0] CH_GRP_B      = 5'd8;
  localparam logic [CH_W-1:0] CH_GRP_C      = 5'd9;
  localparam logic [CH_W-1:0] CH_LOW_RANGE  = 5'd10;
  localparam logic [CH_W-1:0] CH_PASS_FIRST = 5'd15;
  localparam logic [CH_W-1:0] CH_PASS_LAST  = 5'd17;
  localparam logic [CH_W-1:0] CH_GRP_A_ALT  = 5'd18;
  localparam logic [CH_W-1:0] CH_LAST       = 5'd18;

  localparam logic REG_TRIM_LO = 1'b0;
  localparam logic REG_TRIM_HI = 1'b1;

  typedef struct packed {
    logic                     invalid;
    logic                     pass;
    logic [RAW_BITS-1:0]      raw;
    logic [GAIN_W-1:0]        gain;
    logic [K_W-1:0]           k;
    logic signed [B_W-1:0]    b;
  } mid_item_t;

  typedef struct packed {
    logic      valid;
    mid_item_t item;
  } link_t;

  typedef struct packed {
    logic                   status;
    logic signed [CC_W-1:0] cc;
    logic signed [MV_W-1:0] mv;
    logic [RS_W-1:0]        rs;
  } result_t;

  // Ideal gain per channel, (v2 - v1) * 1000 / (x2 - x1) truncated.
  function automatic logic [GAIN_W-1:0] gain_of(input logic [CH_W-1:0] ch);
    logic [GAIN_W-1:0] g;
    unique case (ch) inside
      5'd2, 5'd11:         g = 13'd457;
      5'd7, 5'd8, 5'd18:   g = 13'd1525;
      5'd9:                g = 13'd2746;
      5'd10:               g = 13'd6655;
      5'd14:               g = 13'd1678;
      default:             g = 13'd305;
    endcase
    return g;
  endfunction

endpackage

[rtl/acc_front.sv]
module acc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [acc_pkg::CH_W-1:0]      in_channel,
  input  logic [acc_pkg::RAW_BITS-1:0]  in_raw_code,
  input  logic [63:0]                   trim_lo,
  input  logic [63:0]                   trim_hi,
  input  logic                          mq_pop,
  output acc_pkg::link_t                mq_push
);
  import acc_pkg::*;

  typedef struct packed {
    logic                    invalid;
    logic                    pass;
    logic                    low;
    logic [RAW_BITS-1:0]     raw;
    logic [GAIN_W-1:0]       gain;
    logic signed [D_W-1:0]   d1;
    logic signed [D_W-1:0]   d2;
    logic                    neg;
    logic [M_W-1:0]          m;
    logic [Q_W-1:0]          q;
  } fe_t;

  function automatic logic signed [D_W-1:0] smag(input logic [7:0] mag, input logic s);
    logic signed [D_W-1:0] v;
    v = $signed({2'b00, mag});
    return s ? -v : v;
  endfunction

  logic [7:0] tb [1:16];
  for (genvar i = 0; i < 8; i++) begin : g_tb
    assign tb[i+1] = trim_lo[8*i +: 8];
    assign tb[i+9] = trim_hi[8*i +: 8];
  end

  logic                  accept;
  logic [MQ_AW:0]        used_r, used_nxt;
  logic [3:0]            v_r;
  fe_t                   f1_nxt, f1_r, f2_nxt, f2_r, f3_nxt, f3_r;
  logic signed [D_W-1:0] a1, a2, d1, d2;
  logic signed [D_W:0]   diff;
  logic [D_W-1:0]        dmag;
  logic [M_W+RECIP_W-1:0] qprod;
  logic [K_W:0]          ksum;
  logic [X_W-1:0]        x1;
  logic [Q_W+X_W-1:0]    qx;
  logic signed [B_W-1:0] d1k;
  mid_item_t             f4_nxt, f4_r;

  assign in_full = (used_r == (MQ_AW+1)'(MQ_DEPTH));
  assign accept  = in_push && !in_full;
  assign used_nxt = used_r + (MQ_AW+1)'(accept) - (MQ_AW+1)'(mq_pop);

  always_comb begin
    a1 = smag({1'b0, tb[3][4:0], tb[1][2:1]}, tb[1][0]);
    a2 = smag({tb[4][5:0], tb[2][2:1]}, tb[2][0]);
    unique case (in_channel) inside
      CH_GRP_B: begin
        d1 = a1 + smag({2'b00, tb[8][4:3], tb[7][4:1]}, tb[7][0]);
        d2 = a2 + smag({1'b0, tb[10][4:0], tb[8][2:1]}, tb[8][0]);
      end
      CH_GRP_C: begin
        d1 = a1 + smag({2'b00, tb[14][4:3], tb[12][4:1]}, tb[12][0]);
        d2 = a2 + smag({1'b0, tb[16][4:0], tb[14][2:1]}, tb[14][0]);
      end
      CH_LOW_RANGE: begin
        d1 = smag({1'b0, tb[11][3:0], tb[9][3:1]}, tb[9][0]);
        d2 = smag({1'b0, tb[15][3:0], tb[13][3:1]}, tb[13][0]);
      end
      CH_GRP_A, CH_GRP_A_ALT: begin
        d1 = a1 + smag({2'b00, tb[5][6:1]}, tb[5][0]);
        d2 = a2 + smag({1'b0, tb[6][7:1]}, tb[6][0]);
      end
      default: begin
        d1 = a1;
        d2 = a2;
      end
    endcase
    f1_nxt         = '0;
    f1_nxt.invalid = (in_channel > CH_LAST);
    f1_nxt.pass    = (in_channel >= CH_PASS_FIRST) && (in_channel <= CH_PASS_LAST);
    f1_nxt.low     = (in_channel == CH_LOW_RANGE);
    f1_nxt.raw     = in_raw_code[RAW_BITS-1:0];
    f1_nxt.gain    = gain_of(in_channel);
    f1_nxt.d1      = d1;
    f1_nxt.d2      = d2;
  end

  // Stage 2: delta difference magnitude times 1000.
  always_comb begin
    diff       = (D_W+1)'(f1_r.d2) - (D_W+1)'(f1_r.d1);
    dmag       = D_W'(diff[D_W] ? -diff : diff);
    f2_nxt     = f1_r;
    f2_nxt.neg = diff[D_W];
    f2_nxt.m   = M_W'(dmag) * M_W'(SCALE);
  end

  // Stage 3: divide by the code span through its reciprocal.
  always_comb begin
    qprod    = (M_W+RECIP_W)'(f2_r.m) *
               (M_W+RECIP_W)'(f2_r.low ? RECIP_DX_LOW : RECIP_DX_MAIN);
    f3_nxt   = f2_r;
    f3_nxt.q = qprod[RECIP_SHIFT +: Q_W];
  end

  // Stage 4: gain error k and offset b.
  always_comb begin
    ksum  = f3_r.neg ? ((K_W+1)'(SCALE) - (K_W+1)'(f3_r.q))
                     : ((K_W+1)'(SCALE) + (K_W+1)'(f3_r.q));
    x1    = f3_r.low ? X_W'(X1_LOW) : X_W'(X1_MAIN);
    qx    = (Q_W+X_W)'(f3_r.q) * (Q_W+X_W)'(x1);
    d1k   = B_W'(f3_r.d1) * $signed(B_W'(SCALE));
    f4_nxt.invalid = f3_r.invalid;
    f4_nxt.pass    = f3_r.pass;
    f4_nxt.raw     = f3_r.raw;
    f4_nxt.gain    = f3_r.gain;
    f4_nxt.k       = K_W'(ksum);
    f4_nxt.b       = f3_r.neg ? (d1k + $signed({1'b0, qx})) : (d1k - $signed({1'b0, qx}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      v_r    <= '0;
    end else begin
      used_r <= used_nxt;
      v_r    <= {v_r[2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    f1_r <= f1_nxt;
    f2_r <= f2_nxt;
    f3_r <= f3_nxt;
    f4_r <= f4_nxt;
  end

  assign mq_push.valid = v_r[3];
  assign mq_push.item  = f4_r;

endmodule

[rtl/acc_queue.sv]
module acc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  acc_pkg::link_t wr,
  input  logic           pop,
  output acc_pkg::link_t head
);
  import acc_pkg::*;

  mid_item_t        mem_r [MQ_DEPTH];
  logic [MQ_AW-1:0] wp_r, rp_r;
  logic [MQ_AW:0]   cnt_r;
  logic             do_pop;

  assign do_pop     = pop && (cnt_r != '0);
  assign head.valid = (cnt_r != '0);
  assign head.item  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr.valid) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (MQ_AW+1)'(wr.valid) - (MQ_AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (wr.valid) begin
      mem_r[wp_r] <= wr.item;
    end
  end

endmodule

[rtl/acc_back.sv]
module acc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  acc_pkg::link_t   issue,
  output logic             res_valid,
  output acc_pkg::result_t res
);
  import acc_pkg::*;

  localparam int PM_W  = CCM_W + GAIN_W;
  localparam int PR_W  = RAW_BITS + GAIN_W;
  localparam int MVM_W = PM_W + R1K_W - R1K_SHIFT;
  localparam int RSV_W = PR_W + R1K_W - R1K_SHIFT;

  typedef struct packed {
    logic                invalid;
    logic                pass;
    logic [RAW_BITS-1:0] raw;
    logic [GAIN_W-1:0]   gain;
    logic [K_W-1:0]      k;
    logic                neg;
    logic [N_W-1:0]      num;
    logic [K_W-1:0]      rem;
    logic [N_W-1:0]      quo;
  } dv_t;

  typedef struct packed {
    logic                   invalid;
    logic                   pass;
    logic [RAW_BITS-1:0]    raw;
    logic                   neg;
    logic signed [CC_W-1:0] cc;
    logic [PM_W-1:0]        pm;
    logic [PR_W-1:0]        pr;
  } p1_t;

  typedef struct packed {
    logic                   invalid;
    logic                   pass;
    logic [RAW_BITS-1:0]    raw;
    logic                   neg;
    logic signed [CC_W-1:0] cc;
    logic [MVM_W-1:0]       mvmag;
    logic [RSV_W-1:0]       rsv;
  } p2_t;

  // One restoring quotient bit per stage.
  function automatic dv_t div_step(input dv_t s);
    dv_t         o;
    logic [K_W:0] trial;
    logic        ge;
    o     = s;
    trial = {s.rem, s.num[N_W-1]};
    ge    = (trial >= {1'b0, s.k});
    o.rem = K_W'(ge ? (trial - {1'b0, s.k}) : trial);
    o.num = {s.num[N_W-2:0], 1'b0};
    o.quo = {s.quo[N_W-2:0], ge};
    return o;
  endfunction

  dv_t                    st_r [0:N_W];
  logic [N_W:0]           sv_r;
  dv_t                    st0_nxt;
  logic [N_W-1:0]         rawk;
  logic signed [N_W:0]    nsig;
  p1_t                    p1_nxt, p1_r;
  p2_t                    p2_nxt, p2_r;
  logic [1:0]             pv_r;
  logic [CCM_W-1:0]       ccmag;
  logic [PM_W+R1K_W-1:0]  mvprod;
  logic [PR_W+R1K_W-1:0]  rsprod;
  logic signed [MVM_W:0]  mvs;

  // Numerator raw * 1000 - b, split into sign and magnitude.
  always_comb begin
    rawk            = N_W'(issue.item.raw) * N_W'(SCALE);
    nsig            = $signed({1'b0, rawk}) - (N_W+1)'(issue.item.b);
    st0_nxt.invalid = issue.item.invalid;
    st0_nxt.pass    = issue.item.pass;
    st0_nxt.raw     = issue.item.raw;
    st0_nxt.gain    = issue.item.gain;
    st0_nxt.k       = issue.item.k;
    st0_nxt.neg     = nsig[N_W];
    st0_nxt.num     = N_W'(nsig[N_W] ? -nsig : nsig);
    st0_nxt.rem     = '0;
    st0_nxt.quo     = '0;
  end

  always_ff @(posedge clk) begin
    st_r[0] <= st0_nxt;
    for (int i = 0; i < N_W; i++) begin
      st_r[i+1] <= div_step(st_r[i]);
    end
  end

  always_comb begin
    ccmag          = st_r[N_W].quo[CCM_W-1:0];
    p1_nxt.invalid = st_r[N_W].invalid;
    p1_nxt.pass    = st_r[N_W].pass;
    p1_nxt.raw     = st_r[N_W].raw;
    p1_nxt.neg     = st_r[N_W].neg;
    p1_nxt.cc      = st_r[N_W].neg ? -$signed({1'b0, ccmag}) : $signed({1'b0, ccmag});
    p1_nxt.pm      = PM_W'(ccmag) * PM_W'(st_r[N_W].gain);
    p1_nxt.pr      = PR_W'(st_r[N_W].raw) * PR_W'(st_r[N_W].gain);
  end

  always_comb begin
    mvprod         = (PM_W+R1K_W)'(p1_r.pm) * (PM_W+R1K_W)'(RECIP_1000);
    rsprod         = (PR_W+R1K_W)'(p1_r.pr) * (PR_W+R1K_W)'(RECIP_1000);
    p2_nxt.invalid = p1_r.invalid;
    p2_nxt.pass    = p1_r.pass;
    p2_nxt.raw     = p1_r.raw;
    p2_nxt.neg     = p1_r.neg;
    p2_nxt.cc      = p1_r.cc;
    p2_nxt.mvmag   = mvprod[R1K_SHIFT +: MVM_W];
    p2_nxt.rsv     = rsprod[R1K_SHIFT +: RSV_W];
  end

  always_ff @(posedge clk) begin
    p1_r <= p1_nxt;
    p2_r <= p2_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
      pv_r <= '0;
    end else begin
      sv_r <= {sv_r[N_W-1:0], issue.valid};
      pv_r <= {pv_r[0], sv_r[N_W]};
    end
  end

  // Sign, saturation and the special channels.
  always_comb begin
    mvs = p2_r.neg ? -$signed({1'b0, p2_r.mvmag}) : $signed({1'b0, p2_r.mvmag});
    res.status = 1'b0;
    if (p2_r.invalid) begin
      res.status = 1'b1;
      res.cc     = '0;
      res.mv     = '0;
      res.rs     = '0;
    end else if (p2_r.pass) begin
      res.cc = $signed(CC_W'(p2_r.raw));
      res.mv = $signed(MV_W'(p2_r.raw));
      res.rs = RS_W'(p2_r.raw);
    end else begin
      res.cc = p2_r.cc;
      if (mvs > MV_MAX) begin
        res.mv = MV_W'(MV_MAX);
      end else if (mvs < MV_MIN) begin
        res.mv = MV_W'(MV_MIN);
      end else begin
        res.mv = MV_W'(mvs);
      end
      res.rs = (p2_r.rsv > RS_MAX) ? RS_W'(RS_MAX) : RS_W'(p2_r.rsv);
    end
  end

  assign res_valid = pv_r[1];

endmodule

[rtl/adc_trim_calibrated_correction_unit.sv]
// Two-point calibrated converter readout.
// Configuration: cfg_we writes cfg_data into trim register cfg_index (0 holds
// trim bytes 1 to 8, 1 holds bytes 9 to 16) at the clock edge; write only while
// the block is idle. Input beats (channel, raw code) are taken when in_push is
// high and in_full is low. Results wait in an output queue; the oldest sits on
// the out_ ports while out_empty is low and leaves on out_pop.
// A front end decodes the trim deltas, builds gain error and offset, and
// hands each beat to an eight-entry queue. The back end forms the numerator,
// runs a 23-stage restoring divider (one quotient bit per stage) and scales
// the results, so a beat reaches the output queue and shows on the out_
// ports. One beat is accepted every cycle while in_full is low.
// The back end only issues a beat when the 32-entry output queue has a slot
// reserved for it, so when the receiver stalls the queues fill and in_full
// rises; nothing is dropped. Reset (synchronous, active low) empties all
// queues and clears both trim registers.
module adc_trim_calibrated_correction_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [63:0]                         cfg_data,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [acc_pkg::CH_W-1:0]            in_channel,
  input  logic [acc_pkg::RAW_BITS-1:0]        in_raw_code,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic                                out_status,
  output logic signed [acc_pkg::CC_W-1:0]     out_corr_code,
  output logic signed [acc_pkg::MV_W-1:0]     out_value_mv,
  output logic [acc_pkg::RS_W-1:0]            out_raw_scaled_value
);
  import acc_pkg::*;
  `include "adc_trim_calibrated_correction_unit_macros.svh"

  logic [63:0]      trim_lo_r, trim_hi_r;
  link_t            mq_push, mq_head, issue;
  logic             mq_pop;
  logic             res_valid;
  result_t          res;
  result_t          oq_r [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_wp_r, oq_rp_r;
  logic [OQ_AW:0]   oq_cnt_r;
  logic [OQ_AW:0]   out_used_r;
  logic             out_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trim_lo_r <= '0;
      trim_hi_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_TRIM_LO) begin
        trim_lo_r <= cfg_data;
      end else begin
        trim_hi_r <= cfg_data;
      end
    end
  end

  acc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_channel  (in_channel),
    .in_raw_code (in_raw_code),
    .trim_lo     (trim_lo_r),
    .trim_hi     (trim_hi_r),
    .mq_pop      (mq_pop),
    .mq_push     (mq_push)
  );

  acc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (mq_push),
    .pop   (mq_pop),
    .head  (mq_head)
  );

  // Issue to the back end only with an output slot reserved.
  assign mq_pop      = mq_head.valid && (out_used_r != (OQ_AW+1)'(OQ_DEPTH));
  assign issue.valid = mq_pop;
  assign issue.item  = mq_head.item;

  acc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (issue),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_empty = (oq_cnt_r == '0);
  assign out_acc   = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r    <= '0;
      oq_rp_r    <= '0;
      oq_cnt_r   <= '0;
      out_used_r <= '0;
    end else begin
      if (res_valid) begin
        oq_wp_r <= oq_wp_r + 1'b1;
      end
      if (out_acc) begin
        oq_rp_r <= oq_rp_r + 1'b1;
      end
      oq_cnt_r   <= oq_cnt_r + (OQ_AW+1)'(res_valid) - (OQ_AW+1)'(out_acc);
      out_used_r <= out_used_r + (OQ_AW+1)'(mq_pop) - (OQ_AW+1)'(out_acc);
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      oq_r[oq_wp_r] <= res;
    end
  end

  assign out_status           = oq_r[oq_rp_r].status;
  assign out_corr_code        = oq_r[oq_rp_r].cc;
  assign out_value_mv         = oq_r[oq_rp_r].mv;
  assign out_raw_scaled_value = oq_r[oq_rp_r].rs;

  // Stored results never exceed the reserved slots.
  `ACC_ASSERT_ALWAYS(a_occ_le_credit, oq_cnt_r <= out_used_r)
  // A result from the back end always finds room.
  `ACC_ASSERT_IMP(a_no_overflow, res_valid, oq_cnt_r != (OQ_AW+1)'(OQ_DEPTH))
  // A pop without a new result lowers the occupancy by one.
  `ACC_ASSERT_NEXT(a_pop_count, out_acc && !res_valid, oq_cnt_r + 1'b1 == $past(oq_cnt_r))

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

// The scoreboard keeps the trim registers and a queue of predicted readouts,
// in the order the input beats were accepted.
class readout_scoreboard;
  typedef struct {
    logic                   status;
    logic signed [14:0]     cc;
    logic signed [17:0]     mv;
    logic [14:0]            rs;
  } readout_t;

  logic [63:0] trim_lo;
  logic [63:0] trim_hi;
  readout_t    pending[$];
  int          errors;

  function new();
    trim_lo = '0;
    trim_hi = '0;
    errors  = 0;
  endfunction

  function void write_trim(logic idx, logic [63:0] data);
    if (idx == acc_pkg::REG_TRIM_LO) trim_lo = data;
    else trim_hi = data;
  endfunction

  // Trim byte n, counted from one.
  function int trim_byte(int n);
    logic [63:0] w;
    w = (n <= 8) ? trim_lo : trim_hi;
    return int'((w >> (((n - 1) % 8) * 8)) & 64'hFF);
  endfunction

  function int signed_mag(int mag, int sb);
    return (sb & 1) ? -mag : mag;
  endfunction

  function longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Notes an accepted beat and works out the readout it must produce.
  function void note_sample(logic [4:0] ch, logic [11:0] raw_in);
    readout_t r;
    longint raw, cc, mv, rs, dx, gain, k, b, x1, v1, v2;
    int a1, a2, d1, d2;
    raw = raw_in;
    if (ch > 18) begin
      r.status = 1'b1; r.cc = '0; r.mv = '0; r.rs = '0;
      pending.push_back(r);
      return;
    end
    if (ch >= 15 && ch <= 17) begin
      cc = raw; mv = raw; rs = raw;
    end else begin
      x1 = (ch == 10) ? 150 : 1441;
      dx = (ch == 10) ? 601 : 1835;
      case (ch) inside
        2, 11:     begin v1 = 660;  v2 = 1500; end
        7, 8, 18:  begin v1 = 2200; v2 = 5000; end
        9:         begin v1 = 3960; v2 = 9000; end
        10:        begin v1 = 1000; v2 = 5000; end
        14:        begin v1 = 2420; v2 = 5500; end
        default:   begin v1 = 440;  v2 = 1000; end
      endcase
      gain = ((v2 - v1) * 1000) / dx;
      a1 = signed_mag(((trim_byte(3) & 'h1F) << 2) | ((trim_byte(1) & 'h06) >> 1),
                      trim_byte(1));
      a2 = signed_mag(((trim_byte(4) & 'h3F) << 2) | ((trim_byte(2) & 'h06) >> 1),
                      trim_byte(2));
      case (ch) inside
        8: begin
          d1 = a1 + signed_mag(((trim_byte(8) & 'h18) << 1) |
                               ((trim_byte(7) & 'h1E) >> 1), trim_byte(7));
          d2 = a2 + signed_mag(((trim_byte(10) & 'h1F) << 2) |
                               ((trim_byte(8) & 'h06) >> 1), trim_byte(8));
        end
        9: begin
          d1 = a1 + signed_mag(((trim_byte(14) & 'h18) << 1) |
                               ((trim_byte(12) & 'h1E) >> 1), trim_byte(12));
          d2 = a2 + signed_mag(((trim_byte(16) & 'h1F) << 2) |
                               ((trim_byte(14) & 'h06) >> 1), trim_byte(14));
        end
        10: begin
          d1 = signed_mag(((trim_byte(11) & 'h0F) << 3) |
                          ((trim_byte(9) & 'h0E) >> 1), trim_byte(9));
          d2 = signed_mag(((trim_byte(15) & 'h0F) << 3) |
                          ((trim_byte(13) & 'h0E) >> 1), trim_byte(13));
        end
        7, 18: begin
          d1 = a1 + signed_mag((trim_byte(5) & 'h7E) >> 1, trim_byte(5));
          d2 = a2 + signed_mag((trim_byte(6) & 'hFE) >> 1, trim_byte(6));
        end
        default: begin
          d1 = a1; d2 = a2;
        end
      endcase
      // SystemVerilog division truncates toward zero, as the hardware must.
      k  = 1000 + (longint'(d2 - d1) * 1000) / dx;
      b  = longint'(d1) * 1000 - (k - 1000) * x1;
      rs = (raw * gain) / 1000;
      cc = (raw * 1000 - b) / k;
      mv = (cc * gain) / 1000;
    end
    r.status = 1'b0;
    r.cc = 15'(clamp(cc, -16384, 16383));
    r.mv = 18'(clamp(mv, -131072, 131071));
    r.rs = 15'(clamp(rs, 0, 32767));
    pending.push_back(r);
  endfunction

  // Compares one popped readout with the oldest prediction.
  function void check_readout(logic st, logic signed [14:0] cc,
                              logic signed [17:0] mv, logic [14:0] rs);
    readout_t e;
    if (pending.size() == 0) begin
      $error("unexpected readout: status %0d cc %0d", st, cc);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (st !== e.status) begin
      $error("status: expected %0d, got %0d", e.status, st); errors++;
    end
    if (cc !== e.cc) begin
      $error("corr_code: expected %0d, got %0d", e.cc, cc); errors++;
    end
    if (mv !== e.mv) begin
      $error("value_mv: expected %0d, got %0d", e.mv, mv); errors++;
    end
    if (rs !== e.rs) begin
      $error("raw_scaled_value: expected %0d, got %0d", e.rs, rs); errors++;
    end
  endfunction
endclass

module testbench;
  import acc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [63:0] cfg_data = '0;
  logic in_push = 1'b0;
  logic in_full;
  logic [CH_W-1:0] in_channel = '0;
  logic [RAW_BITS-1:0] in_raw_code = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic out_status;
  logic signed [CC_W-1:0] out_corr_code;
  logic signed [MV_W-1:0] out_value_mv;
  logic [RS_W-1:0] out_raw_scaled_value;

  // Idle rates in percent; the stimulus changes them between phases.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count = 0;

  readout_scoreboard readouts = new();

  adc_trim_calibrated_correction_unit DUT (.*);

  always #5 clk = ~clk;

  // The receiver decides pop for the next cycle at each edge, and checks the
  // beat that the edge itself accepted.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      readouts.check_readout(out_status, out_corr_code, out_value_mv,
                             out_raw_scaled_value);
    out_pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_trim(logic idx, logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    readouts.write_trim(idx, data);
  endtask

  // Presents one beat, holds it until accepted, and notes it then. Gaps are
  // inserted before the beat so that push never drops between beats that
  // follow back to back.
  task automatic send_sample(logic [4:0] ch, logic [11:0] raw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push     <= 1'b1;
    in_channel  <= ch;
    in_raw_code <= raw;
    do @(posedge clk); while (in_full);
    readouts.note_sample(ch, raw);
  endtask

  // Lets all predicted readouts drain, then idles before returning.
  task automatic drain();
    in_push <= 1'b0;
    while (readouts.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    logic [4:0] ch;
    logic [11:0] raw;
    for (int i = 0; i < count; i++) begin
      // Mostly valid channels, some above 18.
      ch = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 19))
                                    : 5'($urandom_range(18));
      case ($urandom_range(3))
        0:       raw = ($urandom_range(1)) ? 12'hFFF : 12'h000;
        default: raw = 12'($urandom);
      endcase
      send_sample(ch, raw);
    end
  endtask

  logic [63:0] trim_sets[4][2];

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset trims, channels 0 to 19 with extreme codes, then three more beats.
    for (int c = 0; c < 20; c++) send_sample(5'(c), (c % 2) ? 12'hFFF : 12'h000);
    send_sample(5'd31, 12'hFFF);
    send_sample(5'd16, 12'hFFF);
    send_sample(5'd10, 12'h001);
    drain();

    trim_sets[0] = '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
    trim_sets[1] = '{64'hFEFE_FEFE_FEFE_FEFE, 64'hFEFE_FEFE_FEFE_FEFE};
    trim_sets[2] = '{64'h5555_AAAA_0101_FFFE, 64'hAAAA_5555_FEFF_0100};
    trim_sets[3] = '{{$urandom, $urandom}, {$urandom, $urandom}};

    for (int s = 0; s < 6; s++) begin
      if (s < 4) begin
        write_trim(REG_TRIM_LO, trim_sets[s][0]);
        write_trim(REG_TRIM_HI, trim_sets[s][1]);
      end else begin
        write_trim(REG_TRIM_LO, {$urandom, $urandom});
        write_trim(REG_TRIM_HI, {$urandom, $urandom});
      end
      // Sender idles lightly and receiver heavily, then the reverse, then neither.
      case (s % 3)
        0: begin send_idle_pct = 8;  recv_idle_pct = 49; end
        1: begin send_idle_pct = 49; recv_idle_pct = 8;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      random_phase(88);
      drain();
    end

    if (readouts.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

[adc_trim_calibrated_correction_unit.f]
+incdir+rtl
rtl/acc_pkg.sv
rtl/acc_front.sv
rtl/acc_queue.sv
rtl/acc_back.sv
rtl/adc_trim_calibrated_correction_unit.sv
sim/testbench.sv
